>>> hdl/address_region_map_paint_lookup_macros.svh
// Assertion macros for the region map block.
`ifndef ADDRESS_REGION_MAP_PAINT_LOOKUP_MACROS_SVH
`define ADDRESS_REGION_MAP_PAINT_LOOKUP_MACROS_SVH
`ifndef SYNTHESIS
`define ARPL_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("region map check failed");
`define ARPL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("region map check failed");
`else
`define ARPL_ASSERT_SAME(label, clk, rstn, ante, cons)
`define ARPL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> hdl/arpl_pkg.sv
`timescale 1ns / 1ps
package arpl_pkg;

    localparam logic OP_PAINT  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] KIND_RUNTIME = 2'd1;
    localparam logic [1:0] KIND_GREY    = 2'd2;

    localparam logic [2:0] ST_ROM_WORD     = 3'd0;
    localparam logic [2:0] ST_NOT_MODELLED = 3'd1;
    localparam logic [2:0] ST_CROSSES      = 3'd2;
    localparam logic [2:0] ST_RUNTIME      = 3'd3;
    localparam logic [2:0] ST_PAINTED      = 3'd4;
    localparam logic [2:0] ST_REJECTED     = 3'd5;

    localparam logic [32:0] WORD_BYTES = 33'd4;

    typedef struct packed {
        logic        opcode;
        logic [31:0] region_start;
        logic [31:0] region_size;
        logic [1:0]  region_kind;
        logic [31:0] rom_base;
        logic [31:0] local_base;
        logic [31:0] lookup_address;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] rom_address;
        logic [31:0] region_offset;
        logic        grey_out;
    } out_t;

    typedef struct packed {
        logic [31:0] first;
        logic [32:0] limit;
        logic [1:0]  kind;
        logic [31:0] rom_origin;
        logic [31:0] loc_origin;
    } span_t;

    typedef enum logic [1:0] {
        RES_PAINTED,
        RES_REJECTED,
        RES_LOOKUP
    } res_sel_t;

    typedef struct packed {
        logic     start;
        logic     scan_step;
        logic     shift_init;
        logic     shift_step;
        logic     fix_l;
        logic     fix_n;
        logic     fix_r;
        logic     commit;
        logic     out_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic is_lookup;
        logic paint_zero;
        logic paint_bad;
    } stat_t;

endpackage

>>> hdl/arpl_dp.sv
`timescale 1ns / 1ps
module arpl_dp #(
    parameter int MAX_SPANS = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  arpl_pkg::in_t  req,
    input  arpl_pkg::cmd_t cmd,
    output arpl_pkg::stat_t stat,
    output arpl_pkg::out_t result
);

    localparam int AW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam int CW = $clog2(MAX_SPANS + 1);
    localparam int NW = CW + 1;

    arpl_pkg::span_t mem [MAX_SPANS];

    arpl_pkg::in_t   req_reg;
    arpl_pkg::span_t rd_data_reg;
    arpl_pkg::span_t lent_reg, rent_reg, hent_reg;
    arpl_pkg::span_t lent_next, rent_next;
    arpl_pkg::out_t  out_reg, out_next;
    logic [CW-1:0]   count_reg, idx_reg, lcnt_reg, ucnt_reg;
    logic            acc_pend_reg, cp_pend_reg;
    logic [AW-1:0]   cp_addr_reg;
    logic            lrem_reg, rrem_reg, hit_reg;

    logic [32:0]     start33, end33;
    logic [NW-1:0]   nlow, n_total, src_base, dst_base, pos, src_idx, dst_idx;
    logic            desc, overflow, scan_rd, shift_rd;
    logic            wr_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    arpl_pkg::span_t wr_data, new_span, e;
    arpl_pkg::out_t  lk_out;
    logic [32:0]     word_end, addr33;
    logic [31:0]     off;

    assign start33  = {1'b0, req_reg.region_start};
    assign end33    = start33 + {1'b0, req_reg.region_size};
    assign nlow     = NW'(lcnt_reg) + NW'(lrem_reg);
    assign n_total  = nlow + NW'(ucnt_reg) + NW'(rrem_reg) + NW'(1);
    assign overflow = n_total > NW'(MAX_SPANS);

    // The upper part of the table moves as one block; copy from the far end
    // when it moves up so that no entry is overwritten before it is read.
    assign src_base = NW'(count_reg) - NW'(ucnt_reg);
    assign dst_base = n_total - NW'(ucnt_reg);
    assign desc     = dst_base > src_base;
    assign pos      = desc ? (NW'(ucnt_reg) - NW'(idx_reg) - NW'(1)) : NW'(idx_reg);
    assign src_idx  = src_base + pos;
    assign dst_idx  = dst_base + pos;

    assign scan_rd  = cmd.scan_step && (idx_reg < count_reg);
    assign shift_rd = cmd.shift_step && (idx_reg < ucnt_reg);
    assign rd_addr  = shift_rd ? src_idx[AW-1:0] : idx_reg[AW-1:0];

    always_comb begin
        new_span.first      = req_reg.region_start;
        new_span.limit      = end33;
        new_span.kind       = req_reg.region_kind;
        new_span.rom_origin = req_reg.rom_base;
        new_span.loc_origin = req_reg.local_base;
        wr_en   = 1'b0;
        wr_addr = cp_addr_reg;
        wr_data = rd_data_reg;
        if (cp_pend_reg) begin
            wr_en = 1'b1;
        end else if (cmd.fix_l && lrem_reg) begin
            wr_en   = 1'b1;
            wr_addr = lcnt_reg[AW-1:0];
            wr_data = lent_reg;
        end else if (cmd.fix_n) begin
            wr_en   = 1'b1;
            wr_addr = nlow[AW-1:0];
            wr_data = new_span;
        end else if (cmd.fix_r && rrem_reg) begin
            wr_en   = 1'b1;
            wr_addr = AW'(nlow + NW'(1));
            wr_data = rent_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (scan_rd || shift_rd) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign e = rd_data_reg;

    always_comb begin
        lent_next       = e;
        lent_next.limit = start33;
        rent_next       = e;
        rent_next.first = end33[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            idx_reg      <= '0;
            acc_pend_reg <= 1'b0;
            cp_pend_reg  <= 1'b0;
        end else begin
            acc_pend_reg <= scan_rd;
            cp_pend_reg  <= shift_rd;
            if (cmd.start || cmd.shift_init) begin
                idx_reg <= '0;
            end else if (scan_rd || shift_rd) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.commit) begin
                count_reg <= n_total[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_rd) begin
            cp_addr_reg <= dst_idx[AW-1:0];
        end
        if (cmd.start) begin
            req_reg  <= req;
            lcnt_reg <= '0;
            ucnt_reg <= '0;
            lrem_reg <= 1'b0;
            rrem_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end else if (acc_pend_reg) begin
            if (e.limit <= start33) begin
                lcnt_reg <= lcnt_reg + CW'(1);
            end else if ({1'b0, e.first} >= end33) begin
                ucnt_reg <= ucnt_reg + CW'(1);
            end else begin
                if ({1'b0, e.first} < start33) begin
                    lrem_reg <= 1'b1;
                    lent_reg <= lent_next;
                end
                if (e.limit > end33) begin
                    rrem_reg <= 1'b1;
                    rent_reg <= rent_next;
                end
            end
            if (e.first <= req_reg.lookup_address) begin
                hit_reg  <= 1'b1;
                hent_reg <= e;
            end
        end
    end

    assign addr33   = {1'b0, req_reg.lookup_address};
    assign word_end = addr33 + arpl_pkg::WORD_BYTES;
    assign off      = req_reg.lookup_address - hent_reg.loc_origin;

    always_comb begin
        lk_out = '0;
        if (!hit_reg) begin
            lk_out.status = arpl_pkg::ST_NOT_MODELLED;
        end else if (word_end > hent_reg.limit) begin
            lk_out.status = (addr33 < hent_reg.limit) ? arpl_pkg::ST_CROSSES
                                                      : arpl_pkg::ST_NOT_MODELLED;
        end else if (hent_reg.kind == arpl_pkg::KIND_RUNTIME) begin
            lk_out.status        = arpl_pkg::ST_RUNTIME;
            lk_out.region_offset = off;
        end else begin
            lk_out.status        = arpl_pkg::ST_ROM_WORD;
            lk_out.region_offset = off;
            lk_out.rom_address   = hent_reg.rom_origin + off;
            lk_out.grey_out      = (hent_reg.kind == arpl_pkg::KIND_GREY);
        end
    end

    always_comb begin
        out_next = '0;
        case (cmd.res_sel)
            arpl_pkg::RES_PAINTED:  out_next.status = arpl_pkg::ST_PAINTED;
            arpl_pkg::RES_REJECTED: out_next.status = arpl_pkg::ST_REJECTED;
            arpl_pkg::RES_LOOKUP:   out_next = lk_out;
            default:                out_next.status = arpl_pkg::ST_REJECTED;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

    assign stat.scan_done  = (idx_reg >= count_reg) && !acc_pend_reg;
    assign stat.shift_done = (idx_reg >= ucnt_reg) && !cp_pend_reg;
    assign stat.is_lookup  = (req_reg.opcode == arpl_pkg::OP_LOOKUP);
    assign stat.paint_zero = (req_reg.region_size == 32'd0);
    assign stat.paint_bad  = (end33[32] && (end33[31:0] != 32'd0)) || overflow;

endmodule

>>> hdl/arpl_ctrl.sv
`timescale 1ns / 1ps
module arpl_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  arpl_pkg::stat_t stat,
    output arpl_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        IDLE, SCAN, DECIDE, SHIFT, FIX_L, FIX_N, FIX_R, DONE
    } state_t;

    state_t             state_reg, state_next;
    arpl_pkg::res_sel_t res_reg, res_next;
    logic               m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.res_sel  = res_reg;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = SCAN;
                end
            end
            SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = DECIDE;
                end
            end
            DECIDE: begin
                state_next = DONE;
                if (stat.is_lookup) begin
                    res_next = arpl_pkg::RES_LOOKUP;
                end else if (stat.paint_zero) begin
                    res_next = arpl_pkg::RES_PAINTED;
                end else if (stat.paint_bad) begin
                    res_next = arpl_pkg::RES_REJECTED;
                end else begin
                    cmd.shift_init = 1'b1;
                    state_next     = SHIFT;
                end
            end
            SHIFT: begin
                cmd.shift_step = 1'b1;
                if (stat.shift_done) begin
                    state_next = FIX_L;
                end
            end
            FIX_L: begin
                cmd.fix_l  = 1'b1;
                state_next = FIX_N;
            end
            FIX_N: begin
                cmd.fix_n  = 1'b1;
                state_next = FIX_R;
            end
            FIX_R: begin
                cmd.fix_r  = 1'b1;
                cmd.commit = 1'b1;
                res_next   = arpl_pkg::RES_PAINTED;
                state_next = DONE;
            end
            DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            res_reg     <= arpl_pkg::RES_PAINTED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            res_reg     <= res_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> hdl/address_region_map_paint_lookup.sv
`timescale 1ns / 1ps
// Sorted map of non-overlapping address regions with paint and word lookup.
// Requests arrive on the s_ channel (s_valid, s_ready, s_payload); every
// request gives exactly one result on the m_ channel (m_valid, m_ready,
// m_payload). opcode 0 paints a region, opcode 1 looks up a 4-byte word.
// The table sits in a memory with one read and one write port and a
// registered read, so every request first scans all n stored regions at
// one entry per cycle.
// A paint that is applied adds a block copy of the regions above the painted
// range (one entry per cycle) and up to three writes: the left remainder, the
// new region and the right remainder. Rejected and zero-size paints end after
// the scan. One request is worked on at a time.
// A new request is taken while the previous result still waits in the output
// register; a stall on m_ready only holds the finished result, and the next
// result waits until the register is free.
// Reset (aresetn low, synchronous) empties the table at once: no clearing
// pass is needed, since only entries below the region count are ever read.
`include "address_region_map_paint_lookup_macros.svh"
module address_region_map_paint_lookup #(
    parameter int MAX_SPANS = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  arpl_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output arpl_pkg::out_t m_payload
);

    arpl_pkg::cmd_t  cmd;
    arpl_pkg::stat_t stat;

    arpl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    arpl_dp #(
        .MAX_SPANS (MAX_SPANS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (s_payload),
        .cmd     (cmd),
        .stat    (stat),
        .result  (m_payload)
    );

    `ARPL_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ARPL_ASSERT_SAME(a_load_when_free, aclk, aresetn, cmd.out_load, !m_valid || m_ready)
    `ARPL_ASSERT_NEXT(a_valid_after_load, aclk, aresetn, cmd.out_load, m_valid)

endmodule
